/* hdl/cpualu_pkg.sv */
// Package for the 8-bit ALU with flag register: opcode codes, the internal
// micro-op class, and the payload and queue status structs used by the modules.
// No dependencies.
package cpualu_pkg;

  // Opcode codes as they arrive on the input channel
  localparam logic [4:0] OPC_ADD   = 5'd0;
  localparam logic [4:0] OPC_ADC   = 5'd1;
  localparam logic [4:0] OPC_ADDSP = 5'd2;
  localparam logic [4:0] OPC_ADD16 = 5'd3;
  localparam logic [4:0] OPC_SUB   = 5'd4;
  localparam logic [4:0] OPC_SBC   = 5'd5;
  localparam logic [4:0] OPC_AND   = 5'd6;
  localparam logic [4:0] OPC_XOR   = 5'd7;
  localparam logic [4:0] OPC_OR    = 5'd8;
  localparam logic [4:0] OPC_DAA   = 5'd9;
  localparam logic [4:0] OPC_CPL   = 5'd10;
  localparam logic [4:0] OPC_SCF   = 5'd11;
  localparam logic [4:0] OPC_CCF   = 5'd12;
  localparam logic [4:0] OPC_RRC   = 5'd13;
  localparam logic [4:0] OPC_RLC   = 5'd14;
  localparam logic [4:0] OPC_RR    = 5'd15;
  localparam logic [4:0] OPC_RL    = 5'd16;
  localparam logic [4:0] OPC_SRA   = 5'd17;
  localparam logic [4:0] OPC_SLA   = 5'd18;
  localparam logic [4:0] OPC_SRL   = 5'd19;
  localparam logic [4:0] OPC_SWAP  = 5'd20;
  localparam logic [4:0] OPC_BIT   = 5'd21;
  localparam logic [4:0] OPC_RES   = 5'd22;
  localparam logic [4:0] OPC_SET   = 5'd23;
  localparam logic [4:0] OPC_COND  = 5'd24;

  // Condition codes
  localparam logic [1:0] CC_Z  = 2'd0;
  localparam logic [1:0] CC_NZ = 2'd1;
  localparam logic [1:0] CC_C  = 2'd2;
  localparam logic [1:0] CC_NC = 2'd3;

  // Flag register bit positions: Z N H C
  localparam int FLG_Z = 3;
  localparam int FLG_N = 2;
  localparam int FLG_H = 1;
  localparam int FLG_C = 0;

  // Decoded operation carried through the queue
  typedef enum logic [4:0] {
    OP_NONE, OP_ADD, OP_ADC, OP_ADDSP, OP_ADD16, OP_SUB, OP_SBC,
    OP_AND, OP_XOR, OP_OR, OP_DAA, OP_CPL, OP_SCF, OP_CCF,
    OP_RRC, OP_RLC, OP_RR, OP_RL, OP_SRA, OP_SLA, OP_SRL,
    OP_SWAP, OP_BIT, OP_RES, OP_SET, OP_COND
  } op_t;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        write_carry;
    logic [2:0]  bit_index;
    logic [1:0]  condition;
  } cpualu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
    logic        condition_met;
  } cpualu_out_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic        write_carry;
    logic [2:0]  bit_index;
    logic [1:0]  condition;
  } cpualu_uop_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } cpualu_qstat_t;

endpackage

/* hdl/cpu_alu_with_flags.sv */
// 8-bit ALU with kept Z/N/H/C flag register: top level.
// Depends on cpualu_pkg, cpualu_front, cpualu_queue, cpualu_exec.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation beat (opcode, operands,
//   write_carry, bit_index, condition). out_valid/out_ready/out_data carry
//   one result beat per operation, in order: result and the four flags
//   after the operation, plus condition_met.
//   An accepted beat is first written into the queue; the execute stage
//   then pops it from the queue head and registers its result and flags
//   in the output register.
//   Throughput: one operation per cycle while the output is not stalled; the
//   flag register is updated in the same execute cycle that reads it, so
//   dependent operations follow each other without gaps.
//   When the receiver stalls, the output register holds its beat, the
//   queue fills up to QUEUE_DEPTH entries, then in_ready drops.
//   Reset (rst_n low, synchronous) clears the flags, empties the queue and
//   drops out_valid.
module cpu_alu_with_flags import cpualu_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  cpualu_in_t  in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cpualu_out_t out_data
);

  cpualu_qstat_t q_stat;
  cpualu_uop_t   push_uop, pop_uop;
  logic          push, pop;

  cpualu_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .uop      (push_uop)
  );

  cpualu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_uop),
    .pop       (pop),
    .pop_data  (pop_uop),
    .q_stat    (q_stat)
  );

  cpualu_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .uop       (pop_uop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/cpualu_front.sv */
// Front end: takes input beats, decodes the opcode into a micro-op class
// and pushes it into the queue. Depends on cpualu_pkg.
module cpualu_front import cpualu_pkg::*; (
  input  logic          in_valid,
  output logic          in_ready,
  input  cpualu_in_t    in_data,
  input  cpualu_qstat_t q_stat,
  output logic          push,
  output cpualu_uop_t   uop
);

  op_t op;

  // Opcode decode; unused codes become a no-op
  always_comb begin
    case (in_data.opcode)
      OPC_ADD:   op = OP_ADD;
      OPC_ADC:   op = OP_ADC;
      OPC_ADDSP: op = OP_ADDSP;
      OPC_ADD16: op = OP_ADD16;
      OPC_SUB:   op = OP_SUB;
      OPC_SBC:   op = OP_SBC;
      OPC_AND:   op = OP_AND;
      OPC_XOR:   op = OP_XOR;
      OPC_OR:    op = OP_OR;
      OPC_DAA:   op = OP_DAA;
      OPC_CPL:   op = OP_CPL;
      OPC_SCF:   op = OP_SCF;
      OPC_CCF:   op = OP_CCF;
      OPC_RRC:   op = OP_RRC;
      OPC_RLC:   op = OP_RLC;
      OPC_RR:    op = OP_RR;
      OPC_RL:    op = OP_RL;
      OPC_SRA:   op = OP_SRA;
      OPC_SLA:   op = OP_SLA;
      OPC_SRL:   op = OP_SRL;
      OPC_SWAP:  op = OP_SWAP;
      OPC_BIT:   op = OP_BIT;
      OPC_RES:   op = OP_RES;
      OPC_SET:   op = OP_SET;
      OPC_COND:  op = OP_COND;
      default:   op = OP_NONE;
    endcase
  end

  // Accept whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  assign uop.op          = op;
  assign uop.operand_a   = in_data.operand_a;
  assign uop.operand_b   = in_data.operand_b;
  assign uop.write_carry = in_data.write_carry;
  assign uop.bit_index   = in_data.bit_index;
  assign uop.condition   = in_data.condition;

endmodule

/* hdl/cpualu_queue.sv */
// Small FIFO of decoded micro-ops between front and back end.
// Depends on cpualu_pkg.
module cpualu_queue import cpualu_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cpualu_uop_t   push_data,
  input  logic          pop,
  output cpualu_uop_t   pop_data,
  output cpualu_qstat_t q_stat
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cpualu_uop_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pointer and count update with explicit wrap
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = mem[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

/* hdl/cpualu_exec.sv */
// Back end: executes one micro-op per cycle (unless the output is stalled)
// against the flag register, registers the result beat. Depends on cpualu_pkg.
module cpualu_exec import cpualu_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cpualu_qstat_t q_stat,
  input  cpualu_uop_t   uop,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output cpualu_out_t   out_data
);

  logic [3:0]  flags_r, flags_nxt;
  logic        out_valid_r;
  cpualu_out_t out_data_r;
  logic [15:0] res_nxt;
  logic        met_nxt;

  logic [7:0]  a, b, res8, bmask, daa_t;
  logic        cin, cadd, csub, sh_out;
  logic [8:0]  sum9, diff9, csx9;
  logic [4:0]  hsum5, hdiff5, hsx5;
  logic [15:0] addsx16;
  logic [16:0] add17;
  logic [11:0] h12;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  // Shared datapath terms
  always_comb begin
    a       = uop.operand_a[7:0];
    b       = uop.operand_b[7:0];
    cin     = flags_r[FLG_C];
    cadd    = (uop.op == OP_ADC) ? cin : 1'b0;
    csub    = (uop.op == OP_SBC) ? cin : 1'b0;
    sum9    = {1'b0, a} + {1'b0, b} + {8'd0, cadd};
    hsum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cadd};
    diff9   = {1'b0, a} - {1'b0, b} - {8'd0, csub};
    hdiff5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, csub};
    addsx16 = uop.operand_a + {{8{b[7]}}, b};
    hsx5    = {1'b0, uop.operand_a[3:0]} + {1'b0, b[3:0]};
    csx9    = {1'b0, uop.operand_a[7:0]} + {1'b0, b};
    add17   = {1'b0, uop.operand_a} + {1'b0, uop.operand_b};
    h12     = {1'b0, uop.operand_a[10:0]} + {1'b0, uop.operand_b[10:0]};
    bmask   = 8'b1 << uop.bit_index;
    // Decimal adjust offset
    daa_t   = {1'b0, cin, cin, 2'b00, flags_r[FLG_H], flags_r[FLG_H], 1'b0};
    if (!flags_r[FLG_N]) begin
      if (a[3:0] > 4'h9) begin
        daa_t = daa_t | 8'h06;
      end
      if (a > 8'h99) begin
        daa_t = daa_t | 8'h60;
      end
    end
  end

  // Per-operation result and flags
  always_comb begin
    res8      = 8'd0;
    sh_out    = 1'b0;
    res_nxt   = 16'd0;
    met_nxt   = 1'b0;
    flags_nxt = flags_r;
    case (uop.op)
      OP_ADD, OP_ADC: begin
        res8      = sum9[7:0];
        flags_nxt = {res8 == 8'd0, 1'b0, hsum5[4],
                     (uop.op == OP_ADC || uop.write_carry) ? sum9[8] : cin};
      end
      OP_SUB, OP_SBC: begin
        res8      = diff9[7:0];
        flags_nxt = {res8 == 8'd0, 1'b1, hdiff5[4],
                     (uop.op == OP_SBC || uop.write_carry) ? diff9[8] : cin};
      end
      OP_ADDSP: begin
        res_nxt   = addsx16;
        flags_nxt = {1'b0, 1'b0, hsx5[4], csx9[8]};
      end
      OP_ADD16: begin
        res_nxt   = add17[15:0];
        flags_nxt = {flags_r[FLG_Z], 1'b0, h12[11], add17[16]};
      end
      OP_AND: begin
        res8      = a & b;
        flags_nxt = {res8 == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res8      = a ^ b;
        flags_nxt = {res8 == 8'd0, 3'b000};
      end
      OP_OR: begin
        res8      = a | b;
        flags_nxt = {res8 == 8'd0, 3'b000};
      end
      OP_DAA: begin
        res8      = flags_r[FLG_N] ? a - daa_t : a + daa_t;
        flags_nxt = {res8 == 8'd0, flags_r[FLG_N], 1'b0, daa_t[6]};
      end
      OP_CPL: begin
        res8      = ~a;
        flags_nxt = {flags_r[FLG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: flags_nxt = {flags_r[FLG_Z], 3'b001};
      OP_CCF: flags_nxt = {flags_r[FLG_Z], 2'b00, ~cin};
      OP_RRC, OP_RLC, OP_RR, OP_RL, OP_SRA, OP_SLA, OP_SRL: begin
        case (uop.op)
          OP_RRC:  begin res8 = {a[0], a[7:1]};     sh_out = a[0]; end
          OP_RLC:  begin res8 = {a[6:0], a[7]};     sh_out = a[7]; end
          OP_RR:   begin res8 = {cin, a[7:1]};      sh_out = a[0]; end
          OP_RL:   begin res8 = {a[6:0], cin};      sh_out = a[7]; end
          OP_SRA:  begin res8 = {a[7], a[7:1]};     sh_out = a[0]; end
          OP_SLA:  begin res8 = {a[6:0], 1'b0};     sh_out = a[7]; end
          default: begin res8 = {1'b0, a[7:1]};     sh_out = a[0]; end
        endcase
        flags_nxt = {res8 == 8'd0, 2'b00, sh_out};
      end
      OP_SWAP: begin
        res8      = {a[3:0], a[7:4]};
        flags_nxt = {res8 == 8'd0, 3'b000};
      end
      OP_BIT: flags_nxt = {(a & bmask) == 8'd0, 1'b0, 1'b1, cin};
      OP_RES: res8 = a & ~bmask;
      OP_SET: res8 = a | bmask;
      OP_COND: begin
        case (uop.condition)
          CC_Z:    met_nxt = flags_r[FLG_Z];
          CC_NZ:   met_nxt = !flags_r[FLG_Z];
          CC_C:    met_nxt = cin;
          CC_NC:   met_nxt = !cin;
          default: met_nxt = 1'b0;
        endcase
      end
      default: ;
    endcase
    // 8-bit ops return their byte in the low half
    if (uop.op != OP_ADDSP && uop.op != OP_ADD16) begin
      res_nxt = {8'd0, res8};
    end
  end

  // Flag register and output beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        flags_r     <= flags_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.result          <= res_nxt;
      out_data_r.zero_flag       <= flags_nxt[FLG_Z];
      out_data_r.subtract_flag   <= flags_nxt[FLG_N];
      out_data_r.half_carry_flag <= flags_nxt[FLG_H];
      out_data_r.carry_flag      <= flags_nxt[FLG_C];
      out_data_r.condition_met   <= met_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_flags_kept: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (uop.op == OP_RES || uop.op == OP_SET || uop.op == OP_COND ||
            uop.op == OP_NONE) |=> flags_r == $past(flags_r))
    else $error("flag-preserving op changed flags");

  a_out_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> {out_data_r.zero_flag, out_data_r.subtract_flag,
                     out_data_r.half_carry_flag, out_data_r.carry_flag} == flags_r)
    else $error("output flags differ from flag register");

endmodule
